FILE: rtl/copy_text_row_deescaper_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the COPY text row de-escaper
// Shared forms for same-cycle and next-cycle implications on the clock.
// ---------------------------------------------------------------------------
`ifndef COPY_TEXT_ROW_DEESCAPER_ASSERT_SVH
`define COPY_TEXT_ROW_DEESCAPER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CTRDE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctrde assertion failed");

// consequent must hold in the cycle after the antecedent
`define CTRDE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctrde assertion failed");

`endif

FILE: rtl/ctrde_pkg.sv
// ---------------------------------------------------------------------------
// ctrde_pkg
// Types, codes and character constants of the COPY text row de-escaper.
// ---------------------------------------------------------------------------
package ctrde_pkg;

   typedef enum logic [7:0] {
      MODE_PLAIN    = 8'b0000_0001,
      MODE_ESC      = 8'b0000_0010,
      MODE_OCT1     = 8'b0000_0100,
      MODE_OCT2     = 8'b0000_1000,
      MODE_HEX1     = 8'b0001_0000,
      MODE_HEX2     = 8'b0010_0000,
      MODE_AFTER_NL = 8'b0100_0000,
      MODE_ERRORED  = 8'b1000_0000
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA        = 2'd0,
      KIND_FIELD_END   = 2'd1,
      KIND_TRAIL_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_DELIMITER   = 2'd0,
      CSR_NULL_LENGTH = 2'd1,
      CSR_NULL_TEXT   = 2'd2
   } csr_index_type;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_X         = 8'h78;

   localparam logic [3:0] RAW_LENGTH_MAX   = 4'd15;
   localparam logic [3:0] NULL_LENGTH_INIT = 4'd2;
   localparam logic [63:0] NULL_TEXT_INIT  = 64'h4E5C;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] held;
      logic [3:0] raw_length;
      logic       raw_match;
   } scan_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic [3:0] null_length;
   } csr_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_buffer;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       is_null;
      logic [9:0] field_index;
      logic       row_done;
      logic       last;
   } result_type;

   // {digit present, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= "0" && b <= "9") begin
         r = {1'b1, 4'(b - "0")};
      end else if (b >= "a" && b <= "f") begin
         r = {1'b1, 4'(b - "a" + 8'd10)};
      end else if (b >= "A" && b <= "F") begin
         r = {1'b1, 4'(b - "A" + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic is_octal(input logic [7:0] b);
      return (b >= "0" && b <= "7");
   endfunction

   // single-letter escapes; anything else stands for itself
   function automatic logic [7:0] escape_char(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      unique case (b)
         "b":     c = 8'd8;
         "f":     c = 8'd12;
         "n":     c = 8'd10;
         "r":     c = 8'd13;
         "t":     c = 8'd9;
         "v":     c = 8'd11;
         default: c = b;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/ctrde_step.sv
// ---------------------------------------------------------------------------
// ctrde_step
// Next scan state and up to three result words for one input item.
// ---------------------------------------------------------------------------
module ctrde_step #(
   parameter int FIELD_INDEX_BITS = 10,
   parameter int MARKER_BYTES     = 8
) (
   input  ctrde_pkg::item_type                         item,
   input  ctrde_pkg::scan_type                         scan,
   input  logic [FIELD_INDEX_BITS-1:0]                 field_count,
   input  ctrde_pkg::csr_type                          csr,
   input  logic [MARKER_BYTES*8-1:0]                   null_text,
   output ctrde_pkg::scan_type                         scan_next,
   output logic [FIELD_INDEX_BITS-1:0]                 field_count_next,
   output ctrde_pkg::result_type [ctrde_pkg::MAX_RESULTS-1:0] results,
   output logic [1:0]                                  result_count
);
   import ctrde_pkg::*;

   // fold one raw byte into the null marker comparison
   function automatic scan_type raw_add(input scan_type s, input logic [7:0] b);
      scan_type   r;
      logic [7:0] m;
      r = s;
      m = 8'(null_text >> {s.raw_length, 3'b000});
      if (!(s.raw_length < csr.null_length && 32'(s.raw_length) < MARKER_BYTES
            && m == b)) begin
         r.raw_match = 1'b0;
      end
      if (s.raw_length != RAW_LENGTH_MAX) begin
         r.raw_length = s.raw_length + 4'd1;
      end
      return r;
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [7:0] b,
                                              input logic nul, input logic done,
                                              input logic [FIELD_INDEX_BITS-1:0] cnt);
      result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.is_null     = nul;
      r.field_index = 10'(cnt);
      r.row_done    = done;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic logic null_hit(input scan_type s);
      return s.raw_match && (s.raw_length == csr.null_length);
   endfunction

   always_comb begin : step_blk
      scan_type                      s;
      logic [FIELD_INDEX_BITS-1:0]   cnt;
      result_type [MAX_RESULTS-1:0]  res;
      logic [1:0]                    n;
      logic                          go_plain;
      logic [7:0]                    b;
      logic [4:0]                    hx;

      s        = scan;
      cnt      = field_count;
      res      = '0;
      n        = 2'd0;
      go_plain = 1'b0;
      b        = item.data_byte;
      hx       = hex_digit(b);

      if (item.byte_valid) begin
         unique case (scan.mode)
            MODE_PLAIN: go_plain = 1'b1;
            MODE_ESC: begin
               s      = raw_add(s, CHAR_BACKSLASH);
               s      = raw_add(s, b);
               s.mode = MODE_PLAIN;
               if (is_octal(b)) begin
                  s.held = {5'b0, b[2:0]};
                  s.mode = MODE_OCT1;
               end else if (b == CHAR_X) begin
                  s.mode = MODE_HEX1;
               end else begin
                  res[n] = make_result(KIND_DATA, escape_char(b), 1'b0, 1'b0, cnt);
                  n      = n + 2'd1;
               end
            end
            MODE_OCT1, MODE_OCT2: begin
               if (is_octal(b)) begin
                  s      = raw_add(s, b);
                  s.held = {s.held[4:0], b[2:0]};
                  if (scan.mode == MODE_OCT1) begin
                     s.mode = MODE_OCT2;
                  end else begin
                     res[n] = make_result(KIND_DATA, s.held, 1'b0, 1'b0, cnt);
                     n      = n + 2'd1;
                     s.mode = MODE_PLAIN;
                  end
               end else begin
                  // short escape: emit the value, then treat the byte as plain
                  res[n]   = make_result(KIND_DATA, s.held, 1'b0, 1'b0, cnt);
                  n        = n + 2'd1;
                  s.mode   = MODE_PLAIN;
                  go_plain = 1'b1;
               end
            end
            MODE_HEX1: begin
               if (hx[4]) begin
                  s      = raw_add(s, b);
                  s.held = {4'b0, hx[3:0]};
                  s.mode = MODE_HEX2;
               end else begin
                  res[n]   = make_result(KIND_DATA, CHAR_X, 1'b0, 1'b0, cnt);
                  n        = n + 2'd1;
                  s.mode   = MODE_PLAIN;
                  go_plain = 1'b1;
               end
            end
            MODE_HEX2: begin
               if (hx[4]) begin
                  s      = raw_add(s, b);
                  res[n] = make_result(KIND_DATA, {s.held[3:0], hx[3:0]}, 1'b0, 1'b0, cnt);
                  n      = n + 2'd1;
                  s.mode = MODE_PLAIN;
               end else begin
                  res[n]   = make_result(KIND_DATA, s.held, 1'b0, 1'b0, cnt);
                  n        = n + 2'd1;
                  s.mode   = MODE_PLAIN;
                  go_plain = 1'b1;
               end
            end
            MODE_AFTER_NL: begin
               res[n] = make_result(KIND_TRAIL_ERROR, 8'd0, 1'b0, 1'b0, cnt);
               n      = n + 2'd1;
               s.mode = MODE_ERRORED;
            end
            MODE_ERRORED: ;
            default: ;
         endcase

         if (go_plain) begin
            // delimiter wins over newline, both over backslash
            if (b == csr.delimiter) begin
               res[n]       = make_result(KIND_FIELD_END, 8'd0, null_hit(s), 1'b0, cnt);
               n            = n + 2'd1;
               s.raw_length = 4'd0;
               s.raw_match  = 1'b1;
               if (cnt != '1) begin
                  cnt = cnt + 1'b1;
               end
            end else if (b == CHAR_NEWLINE) begin
               res[n]       = make_result(KIND_FIELD_END, 8'd0, null_hit(s), 1'b1, cnt);
               n            = n + 2'd1;
               s.raw_length = 4'd0;
               s.raw_match  = 1'b1;
               s.mode       = MODE_AFTER_NL;
            end else if (b == CHAR_BACKSLASH) begin
               s.mode = MODE_ESC;
            end else begin
               s      = raw_add(s, b);
               res[n] = make_result(KIND_DATA, b, 1'b0, 1'b0, cnt);
               n      = n + 2'd1;
            end
         end
      end

      if (item.end_of_buffer) begin
         // flush a pending escape, close the row, drop a lone backslash
         if (s.mode == MODE_OCT1 || s.mode == MODE_OCT2 || s.mode == MODE_HEX2) begin
            res[n] = make_result(KIND_DATA, s.held, 1'b0, 1'b0, cnt);
            n      = n + 2'd1;
         end else if (s.mode == MODE_HEX1) begin
            res[n] = make_result(KIND_DATA, CHAR_X, 1'b0, 1'b0, cnt);
            n      = n + 2'd1;
         end
         if (s.mode != MODE_AFTER_NL && s.mode != MODE_ERRORED) begin
            res[n] = make_result(KIND_FIELD_END, 8'd0, null_hit(s), 1'b1, cnt);
            n      = n + 2'd1;
         end
         s.mode       = MODE_PLAIN;
         s.held       = 8'd0;
         s.raw_length = 4'd0;
         s.raw_match  = 1'b1;
         cnt          = '0;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].last = (2'(i) + 2'd1 == n);
      end

      scan_next        = s;
      field_count_next = cnt;
      results          = res;
      result_count     = n;
   end

endmodule

FILE: rtl/copy_text_row_deescaper.sv
// ---------------------------------------------------------------------------
// copy_text_row_deescaper
// Splits one COPY text row into fields and decodes its backslash escapes.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  req_    | in        | req_valid/req_stall | one raw byte and/or end of buffer
//  rsp_    | out       | rsp_valid/rsp_stall | data byte, field end or error
//  csr_    | in        | csr_valid/csr_ready | register index and write data
//
//  An item is registered on accept and decoded from that register into a
//  four-entry result queue; rsp_ presents the registered head of that queue.
//  One item per cycle while each item yields at most one word and rsp_stall is low;
//  an item of two or three words may hold later items while rsp_ drains the queue.
//  req_stall rises while the held item waits for room for three words.
//  Reset is synchronous; there is no clearing pass.
// ---------------------------------------------------------------------------
module copy_text_row_deescaper #(
   parameter int FIELD_INDEX_BITS = 10,
   parameter int MARKER_BYTES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_null,
   output logic [9:0]  rsp_field_index,
   output logic        rsp_row_done,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import ctrde_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int TEXT_BITS  = MARKER_BYTES * 8;

   item_type                      item_ff;
   logic                          item_valid_ff, item_valid_in;
   scan_type                      scan_ff, scan_in;
   logic [FIELD_INDEX_BITS-1:0]   field_count_ff, field_count_in;
   csr_type                       csr_ff;
   logic [TEXT_BITS-1:0]          null_text_ff;
   result_type                    queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;

   result_type [MAX_RESULTS-1:0]  results;
   logic [1:0]                    result_count;
   logic                          accept, pop, step_go;
   logic [COUNT_BITS-1:0]         pushed;
   result_type                    head;

   ctrde_step #(
      .FIELD_INDEX_BITS (FIELD_INDEX_BITS),
      .MARKER_BYTES     (MARKER_BYTES)
   ) u_step (
      .item             (item_ff),
      .scan             (scan_ff),
      .field_count      (field_count_ff),
      .csr              (csr_ff),
      .null_text        (null_text_ff),
      .scan_next        (scan_in),
      .field_count_next (field_count_in),
      .results          (results),
      .result_count     (result_count)
   );

   // decode only when the queue has room for the worst case, counting this pop
   assign pop       = (count_ff != '0) && !rsp_stall;
   assign step_go   = item_valid_ff &&
                      (count_ff <= COUNT_BITS'(QUEUE_DEPTH - MAX_RESULTS) + COUNT_BITS'(pop));
   assign req_stall = item_valid_ff && !step_go;
   assign accept    = req_valid && !req_stall;

   assign pushed        = step_go ? COUNT_BITS'(result_count) : '0;
   assign item_valid_in = accept ? 1'b1 : (step_go ? 1'b0 : item_valid_ff);
   assign wr_ptr_in     = wr_ptr_ff + PTR_BITS'(pushed);
   assign rd_ptr_in     = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in      = count_ff + pushed - COUNT_BITS'(pop);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         scan_ff        <= '{mode: MODE_PLAIN, held: 8'd0, raw_length: 4'd0, raw_match: 1'b1};
         field_count_ff <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
         csr_ff         <= '{delimiter: CHAR_TAB, null_length: NULL_LENGTH_INIT};
         null_text_ff   <= NULL_TEXT_INIT[TEXT_BITS-1:0];
      end else begin
         item_valid_ff <= item_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         if (step_go) begin
            scan_ff        <= scan_in;
            field_count_ff <= field_count_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_DELIMITER:   csr_ff.delimiter   <= csr_wdata[7:0];
               CSR_NULL_LENGTH: csr_ff.null_length <= csr_wdata[3:0];
               CSR_NULL_TEXT:   null_text_ff       <= csr_wdata[TEXT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload: input word and result queue
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                      end_of_buffer: req_end_of_buffer};
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (step_go && 2'(i) < result_count) begin
            queue_ff[wr_ptr_ff + PTR_BITS'(i)] <= results[i];
         end
      end
   end

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_valid       = (count_ff != '0);
   assign rsp_kind        = head.kind;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_is_null     = head.is_null;
   assign rsp_field_index = head.field_index;
   assign rsp_row_done    = head.row_done;
   assign rsp_last        = head.last;

endmodule

FILE: rtl/ctrde_checker.sv
// ---------------------------------------------------------------------------
// ctrde_checker
// Port-level checks on the result channel of the COPY text row de-escaper.
// ---------------------------------------------------------------------------
`include "copy_text_row_deescaper_assert.svh"

module ctrde_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_null,
   input logic       rsp_row_done,
   input logic       rsp_last
);
   import ctrde_pkg::*;

   `CTRDE_ASSERT_NOW(a_kind_legal, rsp_valid,
      rsp_kind == KIND_DATA || rsp_kind == KIND_FIELD_END || rsp_kind == KIND_TRAIL_ERROR)

   // only data words carry a byte
   `CTRDE_ASSERT_NOW(a_byte_only_data, rsp_valid && rsp_kind != KIND_DATA, rsp_out_byte == 8'd0)

   // null and row flags belong to field ends
   `CTRDE_ASSERT_NOW(a_flags_field_end, rsp_valid && rsp_kind != KIND_FIELD_END,
      !rsp_is_null && !rsp_row_done)

   // nothing follows a row end or an error within the same item
   `CTRDE_ASSERT_NOW(a_row_end_last,
      rsp_valid && (rsp_row_done || rsp_kind == KIND_TRAIL_ERROR), rsp_last)

   `CTRDE_ASSERT_NEXT(a_stall_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte))

endmodule

bind copy_text_row_deescaper ctrde_checker u_checker (.*);
